[rtl/csc_pkg.sv]
// shared types and constants for the causal sequence convolution unit
package csc_pkg;

  // sample and result widths
  localparam int SAMPLE_W = 16;
  localparam int Y_W      = 38;

  // input transfer payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] u_sample;
    logic                       start_req;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic signed [Y_W-1:0] y_value;
    logic                  overflow;
  } out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage

[rtl/csc_ram.sv]
// generic single-write, single-read ram with registered read data
module csc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/causal_sequence_convolution_unit.sv]
// top level of the causal sequence convolution unit
//
// Each accepted pair (x, u) is written at element index i of two history
// rams, then y[i] = sum of x[j] * u[i-j] for j = 0..i is built by one
// multiply-accumulate per cycle over the stored history. in_stall holds the
// input off from the accept until the result is loaded, as the single read
// port of each history ram feeds the one multiplier, so no new item is taken
// while a sum is still being built; an item past MAX_LENGTH elements is not
// stored, goes straight to the hold state and returns zero with overflow set.
// A result that cannot be loaded because the previous one is still stalled
// holds the input off for as long as that stall lasts. start_req restarts
// at element zero, and the sum saturates to the 38-bit signed range. A
// finished result sits in an output register, so the next item is taken
// while it waits for its transfer.
module causal_sequence_convolution_unit
  import csc_pkg::*;
#(
  parameter int MAX_LENGTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int IDX_W = $clog2(MAX_LENGTH + 1);
  localparam int PRD_W = 2 * SAMPLE_W;
  localparam int SUM_W = PRD_W + 1 + $clog2(MAX_LENGTH);
  localparam int ACC_W = (SUM_W > Y_W) ? SUM_W : Y_W;
  localparam logic signed [ACC_W-1:0] Y_MAX_EXT = ACC_W'({1'b0, {(Y_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] Y_MIN_EXT = -Y_MAX_EXT - ACC_W'(1);

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          elem_idx_r;
  logic [AW-1:0]             cur_i_r;
  logic [AW-1:0]             cnt_r;
  logic                      issued_all_r;
  logic                      rd_v_r;
  logic                      pr_v_r;
  logic signed [PRD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      ovf_r;
  logic                      out_valid_r;
  out_t                      out_data_r;

  logic                      in_xfer;
  logic [IDX_W-1:0]          eff_idx;
  logic                      seq_full;
  logic                      issue_v;
  logic                      run_done;
  logic                      out_free;
  logic [AW-1:0]             u_raddr;
  logic [SAMPLE_W-1:0]       x_rdata;
  logic [SAMPLE_W-1:0]       u_rdata;
  logic signed [Y_W-1:0]     y_sat;

  // input side handshake and element index selection
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign eff_idx  = in_data.start_req ? '0 : elem_idx_r;
  assign seq_full = (eff_idx == IDX_W'(MAX_LENGTH));

  // read issue and pipeline drain
  assign issue_v  = (state_r == ST_RUN) && !issued_all_r;
  assign run_done = (state_r == ST_RUN) && issued_all_r && !rd_v_r && !pr_v_r;
  assign u_raddr  = cur_i_r - cnt_r;
  assign out_free = !out_valid_r || !out_stall;

  // history memories
  csc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_x_ram (
    .clk   (clk),
    .we    (in_xfer && !seq_full),
    .waddr (eff_idx[AW-1:0]),
    .wdata (in_data.x_sample),
    .raddr (cnt_r),
    .rdata (x_rdata)
  );

  csc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_u_ram (
    .clk   (clk),
    .we    (in_xfer && !seq_full),
    .waddr (eff_idx[AW-1:0]),
    .wdata (in_data.u_sample),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = seq_full ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // saturation of the accumulated sum
  always_comb begin
    priority if (acc_r > Y_MAX_EXT) begin
      y_sat = Y_MAX_EXT[Y_W-1:0];
    end else if (acc_r < Y_MIN_EXT) begin
      y_sat = Y_MIN_EXT[Y_W-1:0];
    end else begin
      y_sat = acc_r[Y_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elem_idx_r  <= '0;
      rd_v_r      <= 1'b0;
      pr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue_v;
      pr_v_r  <= rd_v_r;
      if (in_xfer) begin
        elem_idx_r <= seq_full ? eff_idx : eff_idx + IDX_W'(1);
      end
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: read counter, multiply, accumulate, result load
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_i_r      <= eff_idx[AW-1:0];
      cnt_r        <= '0;
      issued_all_r <= 1'b0;
      acc_r        <= '0;
      ovf_r        <= seq_full;
    end else begin
      if (issue_v) begin
        if (cnt_r == cur_i_r) begin
          issued_all_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + AW'(1);
        end
      end
      if (pr_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    prod_r <= $signed(x_rdata) * $signed(u_rdata);
    if (state_r == ST_HOLD && out_free) begin
      out_data_r.y_value  <= ovf_r ? '0 : y_sat;
      out_data_r.overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // the upper read address never passes the current element
  a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_v |-> (cnt_r <= cur_i_r))
    else $error("history read beyond current element");

  // an overflow result carries zero
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.overflow) |-> (out_data_r.y_value == '0))
    else $error("overflow result with nonzero value");

  // a stored item starts a summation run
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !seq_full) |=> (state_r == ST_RUN))
    else $error("stored item did not start a run");

  // element index saturates at the stored length
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elem_idx_r <= IDX_W'(MAX_LENGTH))
    else $error("element index beyond stored length");
`endif

endmodule
